>>> hw/rtl/fsrc_pkg.sv
// Package for the flash save record controller: widths, phase and operation codes,
// flash command words, record magic and the byte checksum function.
// No dependencies; imported by flash_save_record_controller.
package fsrc_pkg;

  localparam int AddrW  = 23;
  localparam int WordW  = 16;
  localparam int PollW  = 20;
  localparam int StatW  = 3;
  localparam int HalfW  = 32;
  localparam int CountW = 4;
  localparam int RecN   = 8;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [WordW-1:0] word_t;
  typedef logic [PollW-1:0] poll_t;

  // Request types.
  localparam logic [1:0] REQ_STORE = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_RESP  = 2'd2;

  // Result kinds.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_DONE  = 2'd2;

  // Completion status.
  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_ERASE_TO = 3'd1;
  localparam logic [StatW-1:0] ST_PROG_TO  = 3'd2;
  localparam logic [StatW-1:0] ST_MAGIC    = 3'd3;
  localparam logic [StatW-1:0] ST_CHECKSUM = 3'd4;

  // Transaction phases.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ERASE = 3'd1;
  localparam logic [2:0] PH_PROG  = 3'd2;
  localparam logic [2:0] PH_FLOAD = 3'd3;
  localparam logic [2:0] PH_SLOAD = 3'd4;

  // Write sequence kinds that precede the closing read or completion.
  localparam logic [1:0] SEQ_NONE  = 2'd0;
  localparam logic [1:0] SEQ_ERASE = 2'd1;
  localparam logic [1:0] SEQ_PROG  = 2'd2;
  localparam logic [1:0] SEQ_SRAM  = 2'd3;

  localparam logic [CountW-1:0] LEN_ERASE = 4'd10;
  localparam logic [CountW-1:0] LEN_PROG  = 4'd4;
  localparam logic [CountW-1:0] LEN_SRAM  = 4'd8;
  localparam logic [CountW-1:0] LEN_NONE  = 4'd0;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BACKEND    = 2'd0;
  localparam logic [1:0] CFG_ERASE_LIM  = 2'd1;
  localparam logic [1:0] CFG_PROG_LIM   = 2'd2;
  localparam logic [1:0] CFG_SECTOR     = 2'd3;

  localparam poll_t RST_ERASE_LIM = 20'd1000000;
  localparam poll_t RST_PROG_LIM  = 20'd200000;
  localparam addr_t RST_SECTOR    = 23'h7FF000;

  // Flash command addresses and data.
  localparam addr_t CMD_ADDR_A   = 23'h000555;
  localparam addr_t CMD_ADDR_B   = 23'h0002AA;
  localparam addr_t LOCK_OFFSET  = 23'h000042;
  localparam word_t CMD_UNLOCK_A = 16'h00A9;
  localparam word_t CMD_UNLOCK_B = 16'h0056;
  localparam word_t CMD_ERASE    = 16'h0080;
  localparam word_t CMD_SECTOR   = 16'h0030;
  localparam word_t CMD_PROGRAM  = 16'h00A0;
  localparam word_t CMD_UNLOCKBK = 16'h0060;
  localparam word_t CMD_RESET    = 16'h00F0;
  localparam word_t ERASED_WORD  = 16'hFFFF;

  localparam word_t MAGIC_LOW  = 16'h4253;
  localparam word_t MAGIC_HIGH = 16'h3145;

  function automatic word_t byte_sum(input logic [HalfW-1:0] lo, input logic [HalfW-1:0] hi);
    logic [10:0] acc;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      acc = acc + {3'b000, lo[8*i +: 8]} + {3'b000, hi[8*i +: 8]};
    end
    return {5'b00000, acc};
  endfunction

endpackage

>>> hw/rtl/flash_save_record_controller.sv
// Save record controller: flash erase/program/poll sequencer and SRAM byte port.
// Depends on fsrc_pkg for codes, command words and the checksum function.
//
//  Channel | Direction | Handshake              | Payload
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready    | req_type, store_low, store_high, read_value
//  out     | out       | out_valid / out_ready  | op_kind, word_index, word_value, status,
//          |           |                        | last, loaded_low, loaded_high
//
// An accepted item updates the transaction state in the same cycle and loads a plan
// register; the plan is then played out one result per cycle while out_ready is high, from the next cycle on.
// A store first writes an erase or SRAM sequence, a response at most a program one, a load none.
// A new item is taken in the cycle in which the final result of the previous one leaves.
// Reset is synchronous and leaves the block idle with the register defaults loaded.
module flash_save_record_controller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [fsrc_pkg::AddrW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic [fsrc_pkg::HalfW-1:0]  store_low,
  input  logic [fsrc_pkg::HalfW-1:0]  store_high,
  input  logic [fsrc_pkg::WordW-1:0]  read_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  op_kind,
  output logic [fsrc_pkg::AddrW-1:0]  word_index,
  output logic [fsrc_pkg::WordW-1:0]  word_value,
  output logic [fsrc_pkg::StatW-1:0]  status,
  output logic                        last,
  output logic [fsrc_pkg::HalfW-1:0]  loaded_low,
  output logic [fsrc_pkg::HalfW-1:0]  loaded_high
);
  import fsrc_pkg::*;

  logic        backend_select;
  poll_t       erase_poll_limit;
  poll_t       program_poll_limit;
  addr_t       sector_word_index;

  logic [2:0]        phase, phase_next;
  logic [CountW-1:0] word_count, word_count_next;
  poll_t             polls_left, polls_left_next;
  word_t             expected_value, expected_value_next;
  word_t             record_words [RecN];

  logic              busy;
  logic [CountW-1:0] step;
  logic [1:0]        seq, seq_next;
  addr_t             p_addr, p_addr_next;
  word_t             p_value, p_value_next;
  logic [2*HalfW-1:0] p_data, p_data_next;
  logic              tail_read, tail_read_next;
  addr_t             tail_idx, tail_idx_next;
  logic [StatW-1:0]  tail_status, tail_status_next;
  logic [HalfW-1:0]  tail_lo, tail_lo_next;
  logic [HalfW-1:0]  tail_hi, tail_hi_next;

  logic              plan_valid;
  logic              rec_we_all, rec_we_one;
  word_t             rec_one_value;
  word_t             store_words [RecN];
  word_t             load_words  [RecN];
  word_t             store_sum, load_sum;
  logic [2:0]        prog_n;
  addr_t             prog_addr, poll_addr;
  word_t             prog_word;
  poll_t             polls_dec;
  logic [CountW-1:0] wc_inc;
  logic [CountW-1:0] seq_len;
  logic              in_fire, out_fire;

  assign cfg_ready = 1'b1;
  assign out_valid = busy;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = !busy || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      backend_select     <= 1'b0;
      erase_poll_limit   <= RST_ERASE_LIM;
      program_poll_limit <= RST_PROG_LIM;
      sector_word_index  <= RST_SECTOR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BACKEND:   backend_select     <= cfg_data[0];
        CFG_ERASE_LIM: erase_poll_limit   <= cfg_data[PollW-1:0];
        CFG_PROG_LIM:  program_poll_limit <= cfg_data[PollW-1:0];
        CFG_SECTOR:    sector_word_index  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign store_sum = byte_sum(store_low, store_high);
  assign store_words[0] = MAGIC_LOW;
  assign store_words[1] = MAGIC_HIGH;
  assign store_words[2] = store_low[15:0];
  assign store_words[3] = store_low[31:16];
  assign store_words[4] = store_high[15:0];
  assign store_words[5] = store_high[31:16];
  assign store_words[6] = store_sum;
  assign store_words[7] = ~store_sum;

  always_comb begin
    for (int i = 0; i < RecN - 1; i++) begin
      load_words[i] = record_words[i];
    end
    load_words[RecN-1] = read_value;
  end
  assign load_sum = byte_sum({load_words[3], load_words[2]}, {load_words[5], load_words[4]});

  assign prog_n    = (phase == PH_ERASE) ? 3'd0 : word_count[2:0] + 3'd1;
  assign prog_addr = sector_word_index + {20'd0, prog_n};
  assign prog_word = record_words[prog_n];
  assign poll_addr = (phase == PH_ERASE) ? sector_word_index
                                         : sector_word_index + {19'd0, word_count};
  assign polls_dec = polls_left - 20'd1;
  assign wc_inc    = word_count + 4'd1;

  always_comb begin
    phase_next          = phase;
    word_count_next     = word_count;
    polls_left_next     = polls_left;
    expected_value_next = expected_value;
    rec_we_all          = 1'b0;
    rec_we_one          = 1'b0;
    rec_one_value       = read_value;
    plan_valid          = 1'b0;
    seq_next            = SEQ_NONE;
    p_addr_next         = sector_word_index;
    p_value_next        = '0;
    p_data_next         = {store_high, store_low};
    tail_read_next      = 1'b1;
    tail_idx_next       = sector_word_index;
    tail_status_next    = ST_OK;
    tail_lo_next        = '0;
    tail_hi_next        = '0;
    case (req_type)
      REQ_STORE: begin
        if (phase == PH_IDLE) begin
          plan_valid = 1'b1;
          if (backend_select) begin
            seq_next       = SEQ_SRAM;
            tail_read_next = 1'b0;
          end else begin
            rec_we_all          = 1'b1;
            seq_next            = SEQ_ERASE;
            word_count_next     = '0;
            expected_value_next = ERASED_WORD;
            if (erase_poll_limit == '0) begin
              tail_read_next   = 1'b0;
              tail_status_next = ST_ERASE_TO;
            end else begin
              polls_left_next = erase_poll_limit;
              phase_next      = PH_ERASE;
            end
          end
        end
      end
      REQ_LOAD: begin
        if (phase == PH_IDLE) begin
          plan_valid      = 1'b1;
          word_count_next = '0;
          if (backend_select) begin
            phase_next    = PH_SLOAD;
            tail_idx_next = '0;
          end else begin
            phase_next = PH_FLOAD;
          end
        end
      end
      REQ_RESP: begin
        case (phase)
          PH_ERASE, PH_PROG: begin
            plan_valid = 1'b1;
            if (read_value == expected_value) begin
              if (phase == PH_PROG && word_count >= 4'd7) begin
                tail_read_next = 1'b0;
                phase_next     = PH_IDLE;
              end else begin
                word_count_next     = {1'b0, prog_n};
                seq_next            = SEQ_PROG;
                p_addr_next         = prog_addr;
                p_value_next        = prog_word;
                expected_value_next = prog_word;
                if (program_poll_limit == '0) begin
                  tail_read_next   = 1'b0;
                  tail_status_next = ST_PROG_TO;
                  phase_next       = PH_IDLE;
                end else begin
                  polls_left_next = program_poll_limit;
                  tail_idx_next   = prog_addr;
                  phase_next      = PH_PROG;
                end
              end
            end else begin
              polls_left_next = polls_dec;
              if (polls_dec == '0) begin
                tail_read_next   = 1'b0;
                tail_status_next = (phase == PH_ERASE) ? ST_ERASE_TO : ST_PROG_TO;
                phase_next       = PH_IDLE;
              end else begin
                tail_idx_next = poll_addr;
              end
            end
          end
          PH_FLOAD: begin
            plan_valid      = 1'b1;
            rec_we_one      = 1'b1;
            word_count_next = wc_inc;
            if (wc_inc == 4'd8) begin
              tail_read_next = 1'b0;
              phase_next     = PH_IDLE;
              if (load_words[0] != MAGIC_LOW || load_words[1] != MAGIC_HIGH) begin
                tail_status_next = ST_MAGIC;
              end else if (load_words[6] != load_sum || load_words[7] != ~load_sum) begin
                tail_status_next = ST_CHECKSUM;
              end else begin
                tail_lo_next = {load_words[3], load_words[2]};
                tail_hi_next = {load_words[5], load_words[4]};
              end
            end else begin
              tail_idx_next = sector_word_index + {19'd0, wc_inc};
            end
          end
          PH_SLOAD: begin
            plan_valid      = 1'b1;
            rec_we_one      = 1'b1;
            rec_one_value   = {8'd0, read_value[7:0]};
            word_count_next = wc_inc;
            if (wc_inc == 4'd8) begin
              tail_read_next = 1'b0;
              phase_next     = PH_IDLE;
              tail_lo_next   = {record_words[3][7:0], record_words[2][7:0],
                                record_words[1][7:0], record_words[0][7:0]};
              tail_hi_next   = {read_value[7:0], record_words[6][7:0],
                                record_words[5][7:0], record_words[4][7:0]};
            end else begin
              tail_idx_next = {19'd0, wc_inc};
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      word_count     <= '0;
      polls_left     <= '0;
      expected_value <= '0;
    end else if (in_fire) begin
      phase          <= phase_next;
      word_count     <= word_count_next;
      polls_left     <= polls_left_next;
      expected_value <= expected_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && rec_we_all) begin
      for (int i = 0; i < RecN; i++) begin
        record_words[i] <= store_words[i];
      end
    end else if (in_fire && rec_we_one) begin
      record_words[word_count[2:0]] <= rec_one_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (in_fire && plan_valid) begin
      busy <= 1'b1;
      step <= '0;
    end else if (out_fire) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        step <= step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && plan_valid) begin
      seq         <= seq_next;
      p_addr      <= p_addr_next;
      p_value     <= p_value_next;
      p_data      <= p_data_next;
      tail_read   <= tail_read_next;
      tail_idx    <= tail_idx_next;
      tail_status <= tail_status_next;
      tail_lo     <= tail_lo_next;
      tail_hi     <= tail_hi_next;
    end
  end

  always_comb begin
    case (seq)
      SEQ_ERASE: seq_len = LEN_ERASE;
      SEQ_PROG:  seq_len = LEN_PROG;
      SEQ_SRAM:  seq_len = LEN_SRAM;
      default:   seq_len = LEN_NONE;
    endcase
  end

  always_comb begin
    op_kind     = OP_WRITE;
    word_index  = '0;
    word_value  = '0;
    status      = ST_OK;
    loaded_low  = '0;
    loaded_high = '0;
    last        = 1'b0;
    if (step >= seq_len) begin
      last = 1'b1;
      if (tail_read) begin
        op_kind    = OP_READ;
        word_index = tail_idx;
      end else begin
        op_kind     = OP_DONE;
        status      = tail_status;
        loaded_low  = tail_lo;
        loaded_high = tail_hi;
      end
    end else begin
      case (seq)
        SEQ_ERASE: begin
          case (step)
            4'd0, 4'd1: begin
              word_index = p_addr;
              word_value = CMD_UNLOCKBK;
            end
            4'd2: begin
              word_index = p_addr + LOCK_OFFSET;
              word_value = CMD_UNLOCKBK;
            end
            4'd3: begin
              word_index = '0;
              word_value = CMD_RESET;
            end
            4'd4, 4'd7: begin
              word_index = CMD_ADDR_A;
              word_value = CMD_UNLOCK_A;
            end
            4'd5, 4'd8: begin
              word_index = CMD_ADDR_B;
              word_value = CMD_UNLOCK_B;
            end
            4'd6: begin
              word_index = CMD_ADDR_A;
              word_value = CMD_ERASE;
            end
            default: begin
              word_index = p_addr;
              word_value = CMD_SECTOR;
            end
          endcase
        end
        SEQ_PROG: begin
          case (step)
            4'd0: begin
              word_index = CMD_ADDR_A;
              word_value = CMD_UNLOCK_A;
            end
            4'd1: begin
              word_index = CMD_ADDR_B;
              word_value = CMD_UNLOCK_B;
            end
            4'd2: begin
              word_index = CMD_ADDR_A;
              word_value = CMD_PROGRAM;
            end
            default: begin
              word_index = p_addr;
              word_value = p_value;
            end
          endcase
        end
        default: begin
          word_index = {19'd0, step};
          word_value = {8'd0, p_data[{step[2:0], 3'b000} +: 8]};
        end
      endcase
    end
  end

endmodule
